/* rtl/sha256_pkg.sv */
// Shared types and constants for the SHA-256 message hasher.
// No dependencies; used by the controller, datapath and top level.
package sha256_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumHash   = 8;
  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [5:0]  LenPos    = 6'd56;

  typedef logic [31:0] word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       buf_we;      // write one byte of the current block
    logic [5:0] buf_addr;
    logic [7:0] buf_data;
    logic       cnt_add;     // add 8 to the bit count
    logic       load_w;      // copy the hash words into the working vars
    logic       round_en;    // run one compression round
    logic [5:0] round_idx;
    logic       fold;        // add working vars into the hash words
    logic       reset_hash;  // back to initial values, clear bit count
    logic       shift_out;   // rotate hash words for digest output
  } dp_cmd_t;

  typedef struct packed {
    logic [63:0] bit_count;
    word_t       hash0;
  } dp_stat_t;

  localparam word_t InitHash [NumHash] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha256_datapath.sv */
// Datapath: bit count, hash words, schedule window holding the block, one round per cycle.
// Depends on sha256_pkg.
module sha256_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha256_pkg::dp_cmd_t  cmd_i,
  output sha256_pkg::dp_stat_t stat_o
);
  import sha256_pkg::*;

  logic [63:0] cnt_q;
  word_t       h_q [NumHash];
  word_t       v_q [NumHash];
  word_t       w_q [16];
  word_t       w_new, t1, t2, s0, s1, wr;

  // The window is kept as a shift line: w_q[0] is the word used this round.
  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    wr = w_q[0];
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[cmd_i.round_idx] + wr;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Block bytes go straight into the window words, first byte in the top lane.
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      w_q[cmd_i.buf_addr[5:2]][{~cmd_i.buf_addr[1:0], 3'b000} +: 8] <= cmd_i.buf_data;
    end else if (cmd_i.round_en) begin
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_w) begin
      for (int j = 0; j < NumHash; j++) begin
        v_q[j] <= h_q[j];
      end
    end else if (cmd_i.round_en) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int j = 0; j < NumHash; j++) h_q[j] <= InitHash[j];
    end else if (cmd_i.reset_hash) begin
      cnt_q <= '0;
      for (int j = 0; j < NumHash; j++) h_q[j] <= InitHash[j];
    end else begin
      if (cmd_i.cnt_add) begin
        cnt_q <= cnt_q + 64'd8;
      end
      if (cmd_i.fold) begin
        for (int j = 0; j < NumHash; j++) h_q[j] <= h_q[j] + v_q[j];
      end else if (cmd_i.shift_out) begin
        for (int j = 0; j < NumHash - 1; j++) h_q[j] <= h_q[j+1];
        h_q[NumHash-1] <= h_q[0];
      end
    end
  end

  assign stat_o.bit_count = cnt_q;
  assign stat_o.hash0     = h_q[0];

endmodule

/* rtl/sha256_controller.sv */
// Controller: accepts bytes, sequences padding, compression and digest output.
// Depends on sha256_pkg.
module sha256_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 byte_valid_i,
  input  logic                 end_of_message_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           word_index_o,
  output logic [31:0]          digest_word_o,
  output logic                 last_word_o,
  output sha256_pkg::dp_cmd_t  cmd_o,
  input  sha256_pkg::dp_stat_t stat_i
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StLoad, StRound, StFold, StPad, StLen, StOut
  } state_e;

  state_e      state_q;
  logic [5:0]  round_q, pos_q;
  logic        final_q;   // compression is part of message finish
  logic        lenblk_q;  // the compression in flight is the length block
  logic        pad_pending_q;  // the next finish write is the pad byte
  logic [2:0]  widx_q;
  logic        ovalid_q;
  logic [63:0] len_q;
  logic        acc;
  logic [5:0]  pos;

  assign in_stall_o = (state_q != StIdle);
  assign acc = in_valid_i && !in_stall_o;
  assign pos = stat_i.bit_count[8:3];

  always_comb begin
    cmd_o = '0;
    cmd_o.round_idx = round_q;
    case (state_q)
      StIdle: begin
        cmd_o.buf_we   = acc && byte_valid_i;
        cmd_o.buf_addr = pos;
        cmd_o.buf_data = data_byte_i;
        cmd_o.cnt_add  = acc && byte_valid_i;
      end
      StLoad:  cmd_o.load_w = 1'b1;
      StRound: cmd_o.round_en = 1'b1;
      StFold:  cmd_o.fold = 1'b1;
      StPad: begin
        cmd_o.buf_we   = 1'b1;
        cmd_o.buf_addr = pos_q;
        cmd_o.buf_data = pad_pending_q ? PadByte : 8'h00;
      end
      StLen: begin
        cmd_o.buf_we   = 1'b1;
        cmd_o.buf_addr = pos_q;
        cmd_o.buf_data = len_q[63:56];
      end
      StOut: begin
        cmd_o.shift_out  = ovalid_q && !out_stall_i;
        cmd_o.reset_hash = ovalid_q && !out_stall_i && widx_q == 3'd7;
      end
      default: ;
    endcase
  end

  // Accept, compress; finish: pad byte, zero fill, length bytes; digest output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      round_q       <= '0;
      pos_q         <= '0;
      final_q       <= 1'b0;
      lenblk_q      <= 1'b0;
      pad_pending_q <= 1'b0;
      widx_q        <= '0;
      ovalid_q      <= 1'b0;
      len_q         <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (acc) begin
            final_q       <= end_of_message_i;
            lenblk_q      <= 1'b0;
            pad_pending_q <= end_of_message_i;
            if (byte_valid_i && pos == 6'd63) begin
              state_q <= StLoad;
            end else if (end_of_message_i) begin
              state_q <= StPad;
            end
            // Pad byte goes at the position after the optional byte.
            pos_q <= byte_valid_i ? pos + 6'd1 : pos;
            len_q <= byte_valid_i ? stat_i.bit_count + 64'd8 : stat_i.bit_count;
          end
        end
        StLoad: begin
          round_q <= '0;
          state_q <= StRound;
        end
        StRound: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) state_q <= StFold;
        end
        StFold: begin
          if (!final_q) begin
            state_q <= StIdle;
          end else if (lenblk_q) begin
            state_q  <= StOut;
            widx_q   <= '0;
            ovalid_q <= 1'b1;
          end else begin
            state_q <= StPad;
          end
        end
        StPad: begin
          pad_pending_q <= 1'b0;
          pos_q <= pos_q + 6'd1;
          if (pos_q == 6'd63) state_q <= StLoad;
          else if (pos_q + 6'd1 == LenPos) state_q <= StLen;
        end
        StLen: begin
          pos_q <= pos_q + 6'd1;
          len_q <= {len_q[55:0], 8'h00};
          if (pos_q == 6'd63) begin
            lenblk_q <= 1'b1;
            state_q  <= StLoad;
          end
        end
        StOut: begin
          if (ovalid_q && !out_stall_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              ovalid_q <= 1'b0;
              state_q  <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = ovalid_q;
  assign word_index_o  = widx_q;
  assign digest_word_o = stat_i.hash0;
  assign last_word_o   = (widx_q == 3'd7);

  a_pad_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPad |-> cmd_o.buf_we) else $error("pad write missing");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !acc) else $error("accept while busy");
  a_round_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound && round_q != 6'd63 |=> state_q == StRound)
    else $error("round sequence broken");
  a_out_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == StOut) else $error("output outside out state");
endmodule

/* rtl/sha256_message_hasher_unit.sv */
// Top level of the SHA-256 message hasher: controller plus datapath.
// Depends on sha256_pkg, sha256_controller and sha256_datapath.
//
// Input channel: in_valid_i / in_stall_o with data_byte_i, byte_valid_i,
// end_of_message_i. Output channel: out_valid_o / out_stall_i with
// word_index_o, digest_word_o, last_word_o.
// A byte that fills a 64-byte block starts a compression: load, 64 rounds
// of the single round unit, and the fold into the hash words. An end
// transaction writes the pad byte and zeros up to the length field (one
// buffer byte per cycle), runs one or two compressions, then offers eight
// digest words, one per cycle when the receiver does not stall. While the
// receiver stalls, the current word holds and no input is taken until the
// eighth word is delivered. Reset loads the initial hash values and clears
// the bit count; no clearing pass is needed.
module sha256_message_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  word_index_o,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha256_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .byte_valid_i,
    .end_of_message_i, .out_valid_o, .out_stall_i, .word_index_o,
    .digest_word_o, .last_word_o, .cmd_o(cmd), .stat_i(stat)
  );

  sha256_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat)
  );
endmodule

/* test/sha256_digest_checker.sv */
// Checker for the SHA-256 message hasher: watches both channels, computes
// the expected digest words and compares them. Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  word_index_i,
  input  logic [31:0] digest_word_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_words_o
);
  import sha256_pkg::*;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] word;
    logic        last;
  } digest_entry_t;

  digest_entry_t digest_queue[$];
  logic [31:0] chain_hash [8];
  logic [7:0]  msg_block [64];
  logic [63:0] msg_bits;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_message_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = s1 + w[j-7] + s0 + w[j-16];
    end
    {a, b, c, d, e, f, g, h} = {chain_hash[0], chain_hash[1], chain_hash[2], chain_hash[3],
                                chain_hash[4], chain_hash[5], chain_hash[6], chain_hash[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endtask

  task automatic absorb_transaction(logic [7:0] data, logic valid, logic eom);
    int pos;
    if (valid) begin
      pos = int'(msg_bits[8:3]);
      msg_block[pos] = data;
      msg_bits += 64'd8;
      if (pos == 63) compress_message_block();
    end
    if (eom) begin
      pos = int'(msg_bits[8:3]);
      msg_block[pos] = PadByte;
      pos++;
      if (pos > int'(LenPos)) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress_message_block();
        pos = 0;
      end
      while (pos < int'(LenPos)) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[int'(LenPos) + i] = msg_bits[63 - 8*i -: 8];
      compress_message_block();
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{index: 3'(i), word: chain_hash[i], last: i == 7});
      chain_hash = InitHash;
      msg_bits = '0;
    end
  endtask

  assign pending_words_o = digest_queue.size();

  always @(posedge clk_i) begin
    digest_entry_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      chain_hash = InitHash;
      msg_bits = '0;
      digest_queue.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        absorb_transaction(data_byte_i, byte_valid_i, end_of_message_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected transaction idx=%0d word=%h last=%b", $time,
                   word_index_i, digest_word_i, last_word_i);
          fail_count_o++;
        end else begin
          want = digest_queue.pop_front();
          if (want.index !== word_index_i || want.word !== digest_word_i
              || want.last !== last_word_i) begin
            $display({"%0t: mismatch expected idx=%0d word=%h last=%b, ",
                      "actual idx=%0d word=%h last=%b"},
                     $time, want.index, want.word, want.last,
                     word_index_i, digest_word_i, last_word_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

/* test/sha256_message_hasher_unit_tb.sv */
// Testbench top for the SHA-256 message hasher: drives byte streams with
// random gaps and stalls. Depends on sha256_message_hasher_unit and sha256_digest_checker.
`timescale 1ns / 1ps
module sha256_message_hasher_unit_tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  word_index;
  logic [31:0] digest_word;
  logic        last_word;
  int          fail_count, pending_words;
  int          cycle_count = 0;
  int          stall_left = 0;

  localparam int CycleLimit = 400000;

  always #4 clk = ~clk;

  sha256_message_hasher_unit uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .data_byte_i(data_byte), .byte_valid_i(byte_valid), .end_of_message_i(end_of_message),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .word_index_o(word_index),
    .digest_word_o(digest_word), .last_word_o(last_word));

  sha256_digest_checker checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .data_byte_i(data_byte), .byte_valid_i(byte_valid), .end_of_message_i(end_of_message),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .word_index_i(word_index),
    .digest_word_i(digest_word), .last_word_i(last_word),
    .fail_count_o(fail_count), .pending_words_o(pending_words));

  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
  endfunction

  // Send one transaction; returns after it is accepted, on the falling edge.
  // Valid stays high afterwards so that transactions can follow back to back.
  task automatic send_byte(logic [7:0] data, logic valid, logic eom);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= data;
    byte_valid <= valid;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit eom_carries_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b1, eom_carries_byte && i == len - 1);
    end
    if (!eom_carries_byte || len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver stalls: runs of random length, mostly short, a few long.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int lens [] = '{0, 1, 55, 56, 63, 64};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: empty message, then byte extremes, then padding boundaries.
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b1, 1'b1);
    send_byte(8'hc3, 1'b1, 1'b1);
    foreach (lens[i]) send_message(lens[i], 1'($urandom_range(0, 1)));
    // Let the output drain completely before sending more.
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    for (int n = 0; n < 3; n++)
      send_message($urandom_range(0, 4), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* sha256_message_hasher_unit.f */
rtl/sha256_pkg.sv
rtl/sha256_datapath.sv
rtl/sha256_controller.sv
rtl/sha256_message_hasher_unit.sv
test/sha256_digest_checker.sv
test/sha256_message_hasher_unit_tb.sv
